@@ rtl/sst_pkg.sv @@
// shared types, token codes and character helpers for the shader source tokenizer
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	// token classes
	localparam logic [4:0] K_NEWLINE    = 5'd0;
	localparam logic [4:0] K_MACRO      = 5'd1;
	localparam logic [4:0] K_COMMA      = 5'd2;
	localparam logic [4:0] K_SEMICOLON  = 5'd3;
	localparam logic [4:0] K_LPAREN     = 5'd4;
	localparam logic [4:0] K_RPAREN     = 5'd5;
	localparam logic [4:0] K_LBRACKET   = 5'd6;
	localparam logic [4:0] K_RBRACKET   = 5'd7;
	localparam logic [4:0] K_LBRACE     = 5'd8;
	localparam logic [4:0] K_RBRACE     = 5'd9;
	localparam logic [4:0] K_ADD        = 5'd10;
	localparam logic [4:0] K_SUB        = 5'd11;
	localparam logic [4:0] K_MUL        = 5'd12;
	localparam logic [4:0] K_DIV        = 5'd13;
	localparam logic [4:0] K_REM        = 5'd14;
	localparam logic [4:0] K_XOR        = 5'd15;
	localparam logic [4:0] K_CMP_LTEQ   = 5'd16;
	localparam logic [4:0] K_CMP_LT     = 5'd17;
	localparam logic [4:0] K_CMP_GTEQ   = 5'd18;
	localparam logic [4:0] K_CMP_GT     = 5'd19;
	localparam logic [4:0] K_CMP_OR     = 5'd20;
	localparam logic [4:0] K_OR         = 5'd21;
	localparam logic [4:0] K_CMP_AND    = 5'd22;
	localparam logic [4:0] K_AND        = 5'd23;
	localparam logic [4:0] K_CMP_EQ     = 5'd24;
	localparam logic [4:0] K_ASSIGN     = 5'd25;
	localparam logic [4:0] K_TERNARY    = 5'd26;
	localparam logic [4:0] K_COLON      = 5'd27;
	localparam logic [4:0] K_DOT        = 5'd28;
	localparam logic [4:0] K_CMP_NEQ    = 5'd29;
	localparam logic [4:0] K_LITERAL    = 5'd30;
	localparam logic [4:0] K_IDENTIFIER = 5'd31;

	// characters with a special role
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	typedef enum logic [3:0] {
		M_IDLE,
		M_IDENT,
		M_LITNUM,
		M_LITSUF,
		M_MACRO,
		M_P_LT,
		M_P_GT,
		M_P_OR,
		M_P_AND,
		M_P_EQ,
		M_P_SLASH,
		M_P_BANG,
		M_LINECMT,
		M_BLOCK,
		M_BLOCKSTAR
	} lex_mode_t;

	typedef struct packed {
		logic [4:0] kind;
		logic       has_byte;
		logic [7:0] data_byte;
		logic       token_done;
		logic       last;
	} tok_t;

	// up to three results for one source byte, in order, slot 0 first
	typedef struct packed {
		tok_t [2:0] slot;
		logic [1:0] count;
	} lex_res_t;

	function automatic tok_t mk_tok(logic [4:0] kind, logic has, logic [7:0] b, logic done);
		tok_t t;
		t.kind       = kind;
		t.has_byte   = has;
		t.data_byte  = has ? b : 8'd0;
		t.token_done = done;
		t.last       = 1'b0;
		return t;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// {hit, kind} for characters that are a token on their own
	function automatic logic [5:0] single_kind(logic [7:0] c);
		logic [5:0] r;
		case (c)
			8'h2C:   r = {1'b1, K_COMMA};
			8'h3B:   r = {1'b1, K_SEMICOLON};
			8'h28:   r = {1'b1, K_LPAREN};
			8'h29:   r = {1'b1, K_RPAREN};
			8'h5B:   r = {1'b1, K_LBRACKET};
			8'h5D:   r = {1'b1, K_RBRACKET};
			8'h7B:   r = {1'b1, K_LBRACE};
			8'h7D:   r = {1'b1, K_RBRACE};
			8'h2B:   r = {1'b1, K_ADD};
			8'h2D:   r = {1'b1, K_SUB};
			8'h2A:   r = {1'b1, K_MUL};
			8'h25:   r = {1'b1, K_REM};
			8'h5E:   r = {1'b1, K_XOR};
			8'h3F:   r = {1'b1, K_TERNARY};
			8'h3A:   r = {1'b1, K_COLON};
			8'h2E:   r = {1'b1, K_DOT};
			default: r = {1'b0, K_NEWLINE};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sst_lexer.sv @@
// lexer mode register and the per-byte token logic
`timescale 1ns / 1ps
`default_nettype none

module sst_lexer import sst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output lex_res_t        res
);

	lex_mode_t mode_q;
	lex_mode_t mode_after;
	lex_mode_t mode_next;
	lex_mode_t fr_mode;

	logic       pre_v, fr_v, fl_v, do_fresh;
	tok_t       pre_t, fr_t, fl_t;
	logic [5:0] sk;
	logic       id_char;

	// lexing of a byte from idle
	always_comb begin
		sk      = single_kind(in_byte);
		fr_v    = 1'b0;
		fr_t    = mk_tok(K_NEWLINE, 1'b0, 8'd0, 1'b1);
		fr_mode = M_IDLE;
		if (in_byte == CH_NL) begin
			fr_v = 1'b1;
		end else if (in_byte == CH_SLASH) begin
			fr_mode = M_P_SLASH;
		end else if (in_byte == CH_HASH) begin
			fr_mode = M_MACRO;
		end else if (in_byte == CH_LT) begin
			fr_mode = M_P_LT;
		end else if (in_byte == CH_GT) begin
			fr_mode = M_P_GT;
		end else if (in_byte == CH_BAR) begin
			fr_mode = M_P_OR;
		end else if (in_byte == CH_AMP) begin
			fr_mode = M_P_AND;
		end else if (in_byte == CH_EQ) begin
			fr_mode = M_P_EQ;
		end else if (in_byte == CH_BANG) begin
			fr_mode = M_P_BANG;
		end else if (sk[5]) begin
			fr_v = 1'b1;
			fr_t = mk_tok(sk[4:0], 1'b0, 8'd0, 1'b1);
		end else if (is_digit(in_byte)) begin
			fr_v    = 1'b1;
			fr_t    = mk_tok(K_LITERAL, 1'b1, in_byte, 1'b0);
			fr_mode = M_LITNUM;
		end else if (is_alpha(in_byte) || in_byte == CH_UNDER) begin
			fr_v    = 1'b1;
			fr_t    = mk_tok(K_IDENTIFIER, 1'b1, in_byte, 1'b0);
			fr_mode = M_IDENT;
		end
	end

	// lexing in the current mode; may hand the byte over to the idle lexer
	always_comb begin
		id_char    = is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER
			|| in_byte == CH_DOT;
		pre_v      = 1'b0;
		pre_t      = mk_tok(K_NEWLINE, 1'b0, 8'd0, 1'b1);
		do_fresh   = 1'b0;
		mode_after = mode_q;
		case (mode_q)
			M_IDENT: begin
				pre_v = 1'b1;
				if (id_char) begin
					pre_t = mk_tok(K_IDENTIFIER, 1'b1, in_byte, 1'b0);
				end else begin
					pre_t    = mk_tok(K_IDENTIFIER, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_LITNUM: begin
				pre_v = 1'b1;
				if (is_digit(in_byte) || in_byte == CH_DOT) begin
					pre_t = mk_tok(K_LITERAL, 1'b1, in_byte, 1'b0);
				end else if (is_alpha(in_byte)) begin
					pre_t      = mk_tok(K_LITERAL, 1'b1, in_byte, 1'b0);
					mode_after = M_LITSUF;
				end else begin
					pre_t    = mk_tok(K_LITERAL, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_LITSUF: begin
				pre_v = 1'b1;
				if (is_alpha(in_byte)) begin
					pre_t = mk_tok(K_LITERAL, 1'b1, in_byte, 1'b0);
				end else begin
					pre_t    = mk_tok(K_LITERAL, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_MACRO: begin
				pre_v = 1'b1;
				if (in_byte == CH_NL) begin
					pre_t    = mk_tok(K_MACRO, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end else begin
					pre_t = mk_tok(K_MACRO, 1'b1, in_byte, 1'b0);
				end
			end
			M_P_LT, M_P_GT, M_P_EQ: begin
				pre_v = 1'b1;
				if (in_byte == CH_EQ) begin
					pre_t = mk_tok(mode_q == M_P_LT ? K_CMP_LTEQ :
						mode_q == M_P_GT ? K_CMP_GTEQ : K_CMP_EQ, 1'b0, 8'd0, 1'b1);
					mode_after = M_IDLE;
				end else begin
					pre_t = mk_tok(mode_q == M_P_LT ? K_CMP_LT :
						mode_q == M_P_GT ? K_CMP_GT : K_ASSIGN, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_P_OR: begin
				pre_v = 1'b1;
				if (in_byte == CH_BAR) begin
					pre_t      = mk_tok(K_CMP_OR, 1'b0, 8'd0, 1'b1);
					mode_after = M_IDLE;
				end else begin
					pre_t    = mk_tok(K_OR, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_P_AND: begin
				pre_v = 1'b1;
				if (in_byte == CH_AMP) begin
					pre_t      = mk_tok(K_CMP_AND, 1'b0, 8'd0, 1'b1);
					mode_after = M_IDLE;
				end else begin
					pre_t    = mk_tok(K_AND, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_P_SLASH: begin
				if (in_byte == CH_SLASH) begin
					mode_after = M_LINECMT;
				end else if (in_byte == CH_STAR) begin
					mode_after = M_BLOCK;
				end else begin
					pre_v    = 1'b1;
					pre_t    = mk_tok(K_DIV, 1'b0, 8'd0, 1'b1);
					do_fresh = 1'b1;
				end
			end
			M_P_BANG: begin
				if (in_byte == CH_EQ) begin
					pre_v      = 1'b1;
					pre_t      = mk_tok(K_CMP_NEQ, 1'b0, 8'd0, 1'b1);
					mode_after = M_IDLE;
				end else begin
					do_fresh = 1'b1;
				end
			end
			M_LINECMT: begin
				do_fresh = (in_byte == CH_NL);
			end
			M_BLOCK: begin
				if (in_byte == CH_STAR) begin
					mode_after = M_BLOCKSTAR;
				end else if (in_byte == CH_NL) begin
					pre_v = 1'b1;
				end
			end
			M_BLOCKSTAR: begin
				if (in_byte == CH_SLASH) begin
					mode_after = M_IDLE;
				end else if (in_byte != CH_STAR) begin
					mode_after = M_BLOCK;
					pre_v      = (in_byte == CH_NL);
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase
		if (do_fresh) begin
			mode_after = fr_mode;
		end
	end

	// closing an open token or pending operator at end of text
	always_comb begin
		fl_v      = 1'b0;
		fl_t      = mk_tok(K_NEWLINE, 1'b0, 8'd0, 1'b1);
		mode_next = mode_after;
		if (end_of_text) begin
			mode_next = M_IDLE;
			fl_v      = 1'b1;
			case (mode_after)
				M_IDENT:             fl_t.kind = K_IDENTIFIER;
				M_LITNUM, M_LITSUF:  fl_t.kind = K_LITERAL;
				M_MACRO:             fl_t.kind = K_MACRO;
				M_P_LT:              fl_t.kind = K_CMP_LT;
				M_P_GT:              fl_t.kind = K_CMP_GT;
				M_P_OR:              fl_t.kind = K_OR;
				M_P_AND:             fl_t.kind = K_AND;
				M_P_EQ:              fl_t.kind = K_ASSIGN;
				M_P_SLASH:           fl_t.kind = K_DIV;
				default:             fl_v      = 1'b0;
			endcase
		end
	end

	// pack the present results into slots and mark the final one
	always_comb begin
		res.slot[0] = pre_v ? pre_t : ((do_fresh && fr_v) ? fr_t : fl_t);
		res.slot[1] = (pre_v && do_fresh && fr_v) ? fr_t : fl_t;
		res.slot[2] = fl_t;
		res.count   = {1'b0, pre_v} + {1'b0, do_fresh && fr_v} + {1'b0, fl_v};
		case (res.count)
			2'd1:    res.slot[0].last = 1'b1;
			2'd2:    res.slot[1].last = 1'b1;
			2'd3:    res.slot[2].last = 1'b1;
			default: res.slot[0].last = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
		end else if (accept) begin
			mode_q <= mode_next;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sst_outbuf.sv @@
// three-entry result register that hands tokens out one per transfer
`timescale 1ns / 1ps
`default_nettype none

module sst_outbuf import sst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire lex_res_t   res,
	output logic            free,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic [6:0]      m_tuser,
	output logic            m_tlast
);

	tok_t [2:0] buf_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign free     = (cnt_q == 2'd0) || (pop && cnt_q == 2'd1);

	assign m_tdata = buf_q[0].data_byte;
	assign m_tuser = {buf_q[0].token_done, buf_q[0].has_byte, buf_q[0].kind};
	assign m_tlast = buf_q[0].last;

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.slot;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/shader_source_tokenizer_top.sv @@
// top level of the shader source tokenizer
`timescale 1ns / 1ps
`default_nettype none

// shader source tokenizer: takes C-style shader text one byte per transfer
// and returns tokens. each source byte yields zero to three tokens; a byte is
// lexed in the cycle it is taken, against the one-byte lookahead mode, and its
// tokens land together in a three-entry result register that drains one token
// per output transfer. a byte is taken in every cycle while its tokens fit: a
// new byte is accepted whenever the result register is empty or its final
// token leaves in that same cycle, so while the receiver takes every token the
// sustained rate is one byte per cycle for bytes with at most one token; after
// a byte with more tokens, the next byte waits until they drain. identifiers,
// literals and # macros arrive as one data token per character (has_byte set)
// followed by a closing token; operators, punctuation and newlines are single
// closing tokens. comments are dropped but newlines in them still come out. the
// byte marked with s_tlast closes any open token, after which the lexer is back
// to idle. tlast on the output marks the final token caused by one source byte
module shader_source_tokenizer_top import sst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,

	// source byte stream
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // end_of_text

	// token stream
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] data_byte
	output logic [6:0]      m_tuser,   // [4:0] token_kind, [5] has_byte, [6] token_done
	output logic            m_tlast    // last token of this source byte
);

	lex_res_t res;
	logic     free;
	logic     accept;

	// a byte is taken only when its tokens can go straight into the result register
	assign s_tready = free;
	assign accept   = s_tvalid && free;

	sst_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (s_tdata),
		.end_of_text (s_tlast),
		.res         (res)
	);

	// bytes that yield no token only move the lexer mode
	sst_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// a token either carries a character or closes a token, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[5] != m_tuser[6]))
		else $error("token carries both a character and a close");

	// closing tokens carry no character
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[5]) |-> (m_tdata == 8'd0))
		else $error("closing token has nonzero data byte");

	// only identifiers, literals and macros stream characters
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[5]) |-> (m_tuser[4:0] == K_IDENTIFIER
			|| m_tuser[4:0] == K_LITERAL || m_tuser[4:0] == K_MACRO))
		else $error("character token of a wrong class");

endmodule

`default_nettype wire

@@ bench/shader_source_tokenizer_checker.sv @@
// token stream checker: predicts the tokens of each source byte and compares them
`timescale 1ns / 1ps
`default_nettype none

module sst_token_checker import sst_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,
	input  wire logic [6:0] m_tuser,
	input  wire logic       m_tlast,
	output int              mismatches,
	output int              pending
);

	lex_mode_t lex_state = M_IDLE;
	tok_t      byte_toks[$];
	tok_t      expected_toks[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// characters that stand as a token by themselves
	function automatic bit punct_kind(input logic [7:0] c, output logic [4:0] k);
		bit hit;
		hit = 1'b1;
		case (c)
			",":     k = K_COMMA;
			";":     k = K_SEMICOLON;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"[":     k = K_LBRACKET;
			"]":     k = K_RBRACKET;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"+":     k = K_ADD;
			"-":     k = K_SUB;
			"*":     k = K_MUL;
			"%":     k = K_REM;
			"^":     k = K_XOR;
			"?":     k = K_TERNARY;
			":":     k = K_COLON;
			".":     k = K_DOT;
			default: begin
				k   = K_NEWLINE;
				hit = 1'b0;
			end
		endcase
		return hit;
	endfunction

	task automatic add_tok(logic [4:0] kind, logic has, logic [7:0] b, logic done);
		tok_t t;
		t.kind       = kind;
		t.has_byte   = has;
		t.data_byte  = has ? b : 8'd0;
		t.token_done = done;
		t.last       = 1'b0;
		if (byte_toks.size() < 3)
			byte_toks = {byte_toks, t};
	endtask

	// lex a byte as if nothing were open
	task automatic lex_idle(logic [7:0] c);
		logic [4:0] k;
		lex_state = M_IDLE;
		if (c == CH_NL) begin
			add_tok(K_NEWLINE, 1'b0, 8'd0, 1'b1);
		end else if (c == CH_SLASH) begin
			lex_state = M_P_SLASH;
		end else if (c == CH_HASH) begin
			lex_state = M_MACRO;
		end else if (c == CH_LT) begin
			lex_state = M_P_LT;
		end else if (c == CH_GT) begin
			lex_state = M_P_GT;
		end else if (c == CH_BAR) begin
			lex_state = M_P_OR;
		end else if (c == CH_AMP) begin
			lex_state = M_P_AND;
		end else if (c == CH_EQ) begin
			lex_state = M_P_EQ;
		end else if (c == CH_BANG) begin
			lex_state = M_P_BANG;
		end else if (punct_kind(c, k)) begin
			add_tok(k, 1'b0, 8'd0, 1'b1);
		end else if (is_numeral(c)) begin
			add_tok(K_LITERAL, 1'b1, c, 1'b0);
			lex_state = M_LITNUM;
		end else if (is_letter(c) || c == CH_UNDER) begin
			add_tok(K_IDENTIFIER, 1'b1, c, 1'b0);
			lex_state = M_IDENT;
		end
	endtask

	// second character of a possible two-character operator
	task automatic lex_pair(logic [7:0] c, logic [7:0] second, logic [4:0] k_two,
			logic [4:0] k_one);
		if (c == second) begin
			add_tok(k_two, 1'b0, 8'd0, 1'b1);
			lex_state = M_IDLE;
		end else begin
			add_tok(k_one, 1'b0, 8'd0, 1'b1);
			lex_idle(c);
		end
	endtask

	// end of text: close what is open, drop comments
	task automatic close_text();
		case (lex_state)
			M_IDENT:            add_tok(K_IDENTIFIER, 1'b0, 8'd0, 1'b1);
			M_LITNUM, M_LITSUF: add_tok(K_LITERAL, 1'b0, 8'd0, 1'b1);
			M_MACRO:            add_tok(K_MACRO, 1'b0, 8'd0, 1'b1);
			M_P_LT:             add_tok(K_CMP_LT, 1'b0, 8'd0, 1'b1);
			M_P_GT:             add_tok(K_CMP_GT, 1'b0, 8'd0, 1'b1);
			M_P_OR:             add_tok(K_OR, 1'b0, 8'd0, 1'b1);
			M_P_AND:            add_tok(K_AND, 1'b0, 8'd0, 1'b1);
			M_P_EQ:             add_tok(K_ASSIGN, 1'b0, 8'd0, 1'b1);
			M_P_SLASH:          add_tok(K_DIV, 1'b0, 8'd0, 1'b1);
			default:            ;
		endcase
		lex_state = M_IDLE;
	endtask

	task automatic lex_byte(logic [7:0] c, logic eot);
		byte_toks.delete();
		case (lex_state)
			M_IDENT: begin
				if (is_letter(c) || is_numeral(c) || c == CH_UNDER || c == CH_DOT)
					add_tok(K_IDENTIFIER, 1'b1, c, 1'b0);
				else begin
					add_tok(K_IDENTIFIER, 1'b0, 8'd0, 1'b1);
					lex_idle(c);
				end
			end
			M_LITNUM: begin
				if (is_numeral(c) || c == CH_DOT) begin
					add_tok(K_LITERAL, 1'b1, c, 1'b0);
				end else if (is_letter(c)) begin
					add_tok(K_LITERAL, 1'b1, c, 1'b0);
					lex_state = M_LITSUF;
				end else begin
					add_tok(K_LITERAL, 1'b0, 8'd0, 1'b1);
					lex_idle(c);
				end
			end
			M_LITSUF: begin
				if (is_letter(c))
					add_tok(K_LITERAL, 1'b1, c, 1'b0);
				else begin
					add_tok(K_LITERAL, 1'b0, 8'd0, 1'b1);
					lex_idle(c);
				end
			end
			M_MACRO: begin
				if (c == CH_NL) begin
					add_tok(K_MACRO, 1'b0, 8'd0, 1'b1);
					lex_idle(c);
				end else
					add_tok(K_MACRO, 1'b1, c, 1'b0);
			end
			M_P_LT:  lex_pair(c, CH_EQ, K_CMP_LTEQ, K_CMP_LT);
			M_P_GT:  lex_pair(c, CH_EQ, K_CMP_GTEQ, K_CMP_GT);
			M_P_OR:  lex_pair(c, CH_BAR, K_CMP_OR, K_OR);
			M_P_AND: lex_pair(c, CH_AMP, K_CMP_AND, K_AND);
			M_P_EQ:  lex_pair(c, CH_EQ, K_CMP_EQ, K_ASSIGN);
			M_P_SLASH: begin
				if (c == CH_SLASH)
					lex_state = M_LINECMT;
				else if (c == CH_STAR)
					lex_state = M_BLOCK;
				else begin
					add_tok(K_DIV, 1'b0, 8'd0, 1'b1);
					lex_idle(c);
				end
			end
			M_P_BANG: begin
				// a '!' without '=' vanishes
				if (c == CH_EQ) begin
					add_tok(K_CMP_NEQ, 1'b0, 8'd0, 1'b1);
					lex_state = M_IDLE;
				end else
					lex_idle(c);
			end
			M_LINECMT: begin
				if (c == CH_NL)
					lex_idle(c);
			end
			M_BLOCK: begin
				if (c == CH_STAR)
					lex_state = M_BLOCKSTAR;
				else if (c == CH_NL)
					add_tok(K_NEWLINE, 1'b0, 8'd0, 1'b1);
			end
			M_BLOCKSTAR: begin
				if (c == CH_SLASH)
					lex_state = M_IDLE;
				else if (c != CH_STAR) begin
					lex_state = M_BLOCK;
					if (c == CH_NL)
						add_tok(K_NEWLINE, 1'b0, 8'd0, 1'b1);
				end
			end
			default: lex_idle(c);
		endcase
		if (eot)
			close_text();
		if (byte_toks.size() > 0)
			byte_toks[byte_toks.size() - 1].last = 1'b1;
		foreach (byte_toks[i])
			expected_toks = {expected_toks, byte_toks[i]};
	endtask

	task automatic check_token();
		tok_t want;
		if (expected_toks.size() == 0) begin
			$error("token transfer with nothing expected: kind %0d has_byte %0b data %0h",
				m_tuser[4:0], m_tuser[5], m_tdata);
			mismatches++;
		end else begin
			want = expected_toks.pop_front();
			if (m_tuser[4:0] !== want.kind) begin
				$error("token_kind expected %0d actual %0d", want.kind, m_tuser[4:0]);
				mismatches++;
			end
			if (m_tuser[5] !== want.has_byte) begin
				$error("has_byte expected %0b actual %0b", want.has_byte, m_tuser[5]);
				mismatches++;
			end
			if (m_tdata !== want.data_byte) begin
				$error("data_byte expected %0h actual %0h", want.data_byte, m_tdata);
				mismatches++;
			end
			if (m_tuser[6] !== want.token_done) begin
				$error("token_done expected %0b actual %0b", want.token_done, m_tuser[6]);
				mismatches++;
			end
			if (m_tlast !== want.last) begin
				$error("last expected %0b actual %0b", want.last, m_tlast);
				mismatches++;
			end
		end
	endtask

	// tokens leaving this edge come from earlier bytes, so check before predicting
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_state = M_IDLE;
			expected_toks.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_token();
			if (s_tvalid && s_tready)
				lex_byte(s_tdata, s_tlast);
			pending = expected_toks.size();
		end
	end

endmodule

`default_nettype wire

@@ bench/shader_source_tokenizer_top_tb.sv @@
// testbench top for the shader source tokenizer: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
`default_nettype none

module shader_source_tokenizer_top_tb;
	import sst_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_BYTES = 105;
	localparam int MAX_IDLE     = 17;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [6:0] m_tuser;
	logic       m_tlast;

	int mismatches;
	int pending;
	int cycle_count = 0;
	bit calm        = 1'b0;   // both sides run without idling while set

	logic [7:0] frag[$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	shader_source_tokenizer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sst_token_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	function automatic int idle_cycles();
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// one source byte; entered and left at a falling edge
	task automatic send_byte(logic [7:0] b, logic eot);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit eot_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot_at_end && (i == s.len() - 1));
	endtask

	// hold the source back until every predicted token has gone out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// a byte that yields nothing may still be in flight
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
			: 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// append one byte to the fragment
	function automatic void put_byte(logic [7:0] b);
		frag = {frag, b};
	endfunction

	// returns 1 when the fragment should close the text
	function automatic bit build_fragment();
		string ops2[6]  = '{"<=", ">=", "||", "&&", "==", "!="};
		string lone     = "<>|&=!/";
		string punct    = ",;()[]{}+-*%^?:.";
		bit    close_it;
		int    n;
		frag.delete();
		close_it = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 11))
			0, 1: begin
				// identifier
				put_byte($urandom_range(0, 4) == 0 ? CH_UNDER : rand_letter());
				n = $urandom_range(0, 5);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0:       put_byte(8'("0" + $urandom_range(0, 9)));
						1:       put_byte(rand_pick("_."));
						default: put_byte(rand_letter());
					endcase
				end
			end
			2: begin
				// literal: digits and dots, then an optional letter suffix
				put_byte(8'("0" + $urandom_range(0, 9)));
				n = $urandom_range(0, 4);
				repeat (n)
					put_byte($urandom_range(0, 3) == 0 ? CH_DOT
						: 8'("0" + $urandom_range(0, 9)));
				n = $urandom_range(0, 2);
				repeat (n) put_byte(rand_letter());
			end
			3: begin
				// macro line, printable bytes and carriage returns up to the newline
				put_byte(CH_HASH);
				n = $urandom_range(0, 6);
				repeat (n) begin
					if ($urandom_range(0, 5) == 0)
						put_byte(8'h0D);
					else
						put_byte(8'($urandom_range(8'h20, 8'h7E)));
				end
				put_byte(CH_NL);
			end
			4: put_byte(rand_pick(punct));
			5: begin
				// two-character operator, or the first half alone
				if ($urandom_range(0, 1)) begin
					n = $urandom_range(0, 5);
					put_byte(ops2[n][0]);
					put_byte(ops2[n][1]);
				end else begin
					put_byte(rand_pick(lone));
					if ($urandom_range(0, 1))
						put_byte(rand_pick(" a1(\n"));
				end
			end
			6: begin
				put_byte(CH_SLASH);
				put_byte(CH_SLASH);
				n = $urandom_range(0, 4);
				repeat (n) put_byte(rand_pick("ab */#\t"));
				put_byte(CH_NL);
			end
			7: begin
				// block comment with stars and newlines inside
				put_byte(CH_SLASH);
				put_byte(CH_STAR);
				n = $urandom_range(0, 5);
				repeat (n) put_byte(rand_pick("x*\n/ *"));
				if ($urandom_range(0, 3) == 0)
					close_it = 1'b1;   // left open to the end of text
				else begin
					put_byte(CH_STAR);
					put_byte(CH_SLASH);
				end
			end
			8: put_byte(rand_pick(" \t\r\n\n"));
			9: begin
				// noise over the whole byte range
				n = $urandom_range(1, 3);
				repeat (n) put_byte(8'($urandom_range(0, 255)));
			end
			10: begin
				// a text that ends on a lone slash or bang
				put_byte(rand_pick("/!"));
				close_it = 1'b1;
			end
			default: put_byte(8'($urandom_range(0, 255)));
		endcase
		return close_it;
	endfunction

	// receiver: a random stall before every token
	initial begin : token_sink
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk);
		$display("** shader_source_tokenizer_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int  sent;
		bit  close_it;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: byte range extremes as stray bytes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// identifier closed by '<', then '<' left unpaired
		send_text("ab<c", 1'b0);
		// lone bang is dropped, then a real inequality
		send_text("!x!=", 1'b0);
		// end of text with nothing open
		send_text(" ", 1'b1);
		send_text("/", 1'b1);
		send_text("!", 1'b1);
		// unterminated block comment still gives its newline
		send_text("/*\n", 1'b1);
		send_text("9z", 1'b1);
		send_text("#\r\n==", 1'b1);

		// pause the source until the lexer has fully drained
		drain();

		// random text: a clean stretch first, then idling on both sides
		calm = 1'b1;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if (sent >= 40)
				calm = 1'b0;
			close_it = build_fragment();
			foreach (frag[i])
				send_byte(frag[i], close_it && (i == frag.size() - 1));
			sent += frag.size();
			if (sent >= 80 && sent < 80 + frag.size())
				drain();
		end
		send_text("\n", 1'b1);

		drain();
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("** shader_source_tokenizer_top: PASSED **");
		else
			$display("** shader_source_tokenizer_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
